// ===== hw/rtl/min_tracking_stack_assert.svh =====
// assertion macros for the min tracking stack checker
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MTS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("min tracking stack check failed");

// next-cycle implication, disabled while reset is low
`define MTS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("min tracking stack sequencing check failed");

`endif

// ===== hw/rtl/mts_pkg.sv =====
// shared types and codes for the min tracking stack
`timescale 1ns / 1ps

package mts_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int FILL_W   = 7;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;  // capture request, launch memory read
        logic exec;  // apply operation to stack state
    } t_ctrl;

endpackage

// ===== hw/rtl/mts_ctrl.sv =====
// request sequencer for the min tracking stack
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output mts_pkg::t_ctrl o_ctrl
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;
    logic            accept;

    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mts_pkg::S_IDLE: begin
                if (accept) n_state = mts_pkg::S_EXEC;
            end
            mts_pkg::S_EXEC: begin
                n_state = mts_pkg::S_DONE;
            end
            mts_pkg::S_DONE: begin
                n_state = accept ? mts_pkg::S_EXEC : mts_pkg::S_IDLE;
            end
            default: begin
                n_state = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state == mts_pkg::S_EXEC);
    assign o_done      = (r_state == mts_pkg::S_DONE);
    assign o_ctrl.load = accept;
    assign o_ctrl.exec = (r_state == mts_pkg::S_EXEC);

endmodule

// ===== hw/rtl/mts_datapath.sv =====
// stack memory, cached top entry and result registers
`timescale 1ns / 1ps

module mts_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mts_pkg::t_ctrl                      i_ctrl,
    input  logic [mts_pkg::OP_W-1:0]            i_op,
    input  logic signed [mts_pkg::FIELD_W-1:0]  i_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_popped_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_top_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_least_value,
    output logic                                o_is_empty,
    output logic [mts_pkg::STATUS_W-1:0]        o_status,
    output logic [mts_pkg::FILL_W-1:0]          o_fill_count
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = 2 * DATA_WIDTH;

    // entries below the top; the top itself lives in r_top_val / r_top_min
    logic [EW-1:0] mem [STACK_DEPTH];

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic signed [DATA_WIDTH-1:0]    r_top_val;
    logic signed [DATA_WIDTH-1:0]    n_top_val;
    logic signed [DATA_WIDTH-1:0]    r_top_min;
    logic signed [DATA_WIDTH-1:0]    n_top_min;
    logic [mts_pkg::OP_W-1:0]        r_op;
    logic signed [DATA_WIDTH-1:0]    r_value;
    logic [EW-1:0]                   r_rd;
    logic signed [DATA_WIDTH-1:0]    r_popped;
    logic signed [DATA_WIDTH-1:0]    n_popped;
    logic [mts_pkg::STATUS_W-1:0]    r_status;
    logic [mts_pkg::STATUS_W-1:0]    n_status;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic          is_empty_now;
    logic          is_full_now;

    assign cnt_m1       = r_count - CW'(1);
    assign cnt_m2       = r_count - CW'(2);
    assign wr_addr      = cnt_m1[AW-1:0];
    assign rd_addr      = cnt_m2[AW-1:0];
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == CW'(STACK_DEPTH));

    always_comb begin
        n_count   = r_count;
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        n_popped  = '0;
        n_status  = mts_pkg::ST_OK;
        mem_we    = 1'b0;
        case (r_op)
            mts_pkg::OP_PUSH: begin
                if (is_full_now) begin
                    n_status = mts_pkg::ST_OVERFLOW;
                end else begin
                    mem_we    = !is_empty_now;
                    n_top_val = r_value;
                    n_top_min = (!is_empty_now && (r_top_min < r_value)) ? r_top_min : r_value;
                    n_count   = r_count + CW'(1);
                end
            end
            mts_pkg::OP_POP: begin
                if (is_empty_now) begin
                    n_status = mts_pkg::ST_UNDERFLOW;
                end else begin
                    n_popped  = r_top_val;
                    n_top_val = r_rd[EW-1:DATA_WIDTH];
                    n_top_min = r_rd[DATA_WIDTH-1:0];
                    n_count   = cnt_m1;
                end
            end
            default: begin
                // query and the unused code change nothing
            end
        endcase
    end

    // request capture, registered memory read and the write of the old top on a push
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op    <= i_op;
            r_value <= i_value[DATA_WIDTH-1:0];
            r_rd    <= mem[rd_addr];
        end
        if (i_ctrl.exec && mem_we) begin
            mem[wr_addr] <= {r_top_val, r_top_min};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_top_val <= n_top_val;
            r_top_min <= n_top_min;
            r_popped  <= n_popped;
            r_status  <= n_status;
        end
    end

    assign o_is_empty     = is_empty_now;
    assign o_popped_value = mts_pkg::FIELD_W'(r_popped);
    assign o_top_value    = is_empty_now ? '0 : mts_pkg::FIELD_W'(r_top_val);
    assign o_least_value  = is_empty_now ? '0 : mts_pkg::FIELD_W'(r_top_min);
    assign o_status       = r_status;
    assign o_fill_count   = mts_pkg::FILL_W'(r_count);

endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// top level of the min tracking stack
`timescale 1ns / 1ps
//
//  channel   | signals                                   | direction | handshake
//  ----------+-------------------------------------------+-----------+------------------------
//  request   | i_op, i_value                             | in        | start high, busy low
//  result    | o_popped_value .. o_fill_count            | out       | o_done one-cycle strobe
//
//  each request is accepted, which launches the registered read of the entry below the
//  top; the operation is applied in the execute state and o_done is shown in the done
//  state; busy is high only in the execute state, and a new request may be taken
//  while o_done is shown, but not while busy is high
//  the receiver cannot stall: a result is valid only in its o_done cycle
//  i_rst_n is synchronous: it empties the stack; memory contents are not cleared
//
module min_tracking_stack #(
    parameter int STACK_DEPTH = 64,  // entries, 1 to 127
    parameter int DATA_WIDTH  = 32   // stored bits per value, 1 to 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic [mts_pkg::OP_W-1:0]            i_op,
    input  logic signed [mts_pkg::FIELD_W-1:0]  i_value,
    // result
    output logic                                o_done,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_popped_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_top_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  o_least_value,
    output logic                                o_is_empty,
    output logic [mts_pkg::STATUS_W-1:0]        o_status,
    output logic [mts_pkg::FILL_W-1:0]          o_fill_count
);

    // load / execute commands from the sequencer
    mts_pkg::t_ctrl ctrl;

    // sequencer: idle -> execute -> done, with a new request allowed from done
    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctrl  (ctrl)
    );

    // each entry holds its value and the running minimum of itself and all
    // entries below; the top entry is cached so a push needs no read and a
    // pop only reads the entry that becomes the new top
    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_least_value  (o_least_value),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule

// ===== hw/rtl/mts_check.sv =====
// port-level checker for the min tracking stack and its bind
`timescale 1ns / 1ps
`include "min_tracking_stack_assert.svh"

module mts_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_done,
    input logic signed [mts_pkg::FIELD_W-1:0]  o_popped_value,
    input logic signed [mts_pkg::FIELD_W-1:0]  o_top_value,
    input logic signed [mts_pkg::FIELD_W-1:0]  o_least_value,
    input logic                                o_is_empty,
    input logic [mts_pkg::STATUS_W-1:0]        o_status,
    input logic [mts_pkg::FILL_W-1:0]          o_fill_count
);

    // an accepted request moves straight into execution
    `MTS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // execution is always followed by a result strobe with busy low
    `MTS_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy)

    // empty stack reports zero top, zero minimum and zero fill
    `MTS_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_done && o_is_empty,
        o_top_value == '0 && o_least_value == '0 && o_fill_count == '0)

    // underflow leaves an empty stack and pops nothing
    `MTS_ASSERT_IMPLY(a_underflow, i_clk, i_rst_n,
        o_done && (o_status == mts_pkg::ST_UNDERFLOW),
        o_is_empty && o_popped_value == '0)

endmodule

bind min_tracking_stack mts_check u_mts_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_popped_value (o_popped_value),
    .o_top_value    (o_top_value),
    .o_least_value  (o_least_value),
    .o_is_empty     (o_is_empty),
    .o_status       (o_status),
    .o_fill_count   (o_fill_count)
);

// ===== tb/min_tracking_stack_tb.sv =====
// self-checking testbench for the min tracking stack: directed table, then phased random requests
`timescale 1ns / 1ps

module min_tracking_stack_tb;
    import mts_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 750;

    // unassigned op code, the block treats it as a query
    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;

    // one result as the block reports it
    typedef struct packed {
        logic signed [FIELD_W-1:0] popped;
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] min;
        logic                      empty;
        logic [STATUS_W-1:0]       status;
        logic [FILL_W-1:0]         fill;
    } stack_result_t;

    // one line of the directed table; want is used only when typed is set
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [FIELD_W-1:0] value;
        bit                        typed;
        stack_result_t             want;
    } dir_row_t;

    // bias of the random phases
    typedef enum int {
        PH_FILL,
        PH_EMPTY,
        PH_MIXED
    } phase_t;

    localparam stack_result_t EMPTY_OK  = '{32'sd0, 32'sd0, 32'sd0, 1'b1, ST_OK, 7'd0};
    localparam stack_result_t EMPTY_UF  = '{32'sd0, 32'sd0, 32'sd0, 1'b1, ST_UNDERFLOW, 7'd0};
    localparam stack_result_t UNCHECKED = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            i_op;
    logic signed [FIELD_W-1:0]  i_value;
    logic                       o_done;
    logic signed [FIELD_W-1:0]  o_popped_value;
    logic signed [FIELD_W-1:0]  o_top_value;
    logic signed [FIELD_W-1:0]  o_least_value;
    logic                       o_is_empty;
    logic [STATUS_W-1:0]        o_status;
    logic [FILL_W-1:0]          o_fill_count;

    // shadow copy of the stack: value and running minimum per entry
    logic signed [FIELD_W-1:0]  shadow_val [0:STACK_DEPTH-1];
    logic signed [FIELD_W-1:0]  shadow_min [0:STACK_DEPTH-1];
    int                         shadow_fill = 0;

    // results owed by the block, oldest first
    stack_result_t              owed_results [$];

    int err_cnt      = 0;
    int reqs_sent    = 0;
    int results_seen = 0;
    int n_underflow  = 0;
    int n_overflow   = 0;
    int peak_fill    = 0;
    int cycles       = 0;

    min_tracking_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_least_value  (o_least_value),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apply one request to the shadow stack and return what the block should report
    function automatic stack_result_t predict_stack_op(input logic [OP_W-1:0] op,
                                                       input logic signed [FIELD_W-1:0] val);
        stack_result_t r;
        r = '0;
        if (op == OP_PUSH) begin
            if (shadow_fill >= STACK_DEPTH) begin
                r.status = ST_OVERFLOW;
                n_overflow++;
            end else begin
                shadow_val[shadow_fill] = val;
                // an equal value takes the new value as the minimum, which is the same number
                if (shadow_fill > 0 && shadow_min[shadow_fill-1] < val)
                    shadow_min[shadow_fill] = shadow_min[shadow_fill-1];
                else
                    shadow_min[shadow_fill] = val;
                shadow_fill++;
            end
        end else if (op == OP_POP) begin
            if (shadow_fill == 0) begin
                r.status = ST_UNDERFLOW;
                n_underflow++;
            end else begin
                shadow_fill--;
                r.popped = shadow_val[shadow_fill];
            end
        end
        // query and the unassigned code leave the stack alone
        if (shadow_fill > 0) begin
            r.top = shadow_val[shadow_fill-1];
            r.min = shadow_min[shadow_fill-1];
        end else begin
            r.empty = 1'b1;
        end
        r.fill = shadow_fill[FILL_W-1:0];
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // result monitor: the strobe is sampled in the cycle it is shown
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("result strobe with no request outstanding");
                err_cnt++;
            end else begin
                check_field("popped_value", owed_results[0].popped, o_popped_value);
                check_field("top_value", owed_results[0].top, o_top_value);
                check_field("least_value", owed_results[0].min, o_least_value);
                check_field("is_empty", owed_results[0].empty, o_is_empty);
                check_field("status", owed_results[0].status, o_status);
                check_field("fill_count", owed_results[0].fill, o_fill_count);
                void'(owed_results.pop_front());
            end
        end
    end

    // present one request after an optional idle gap and hold it until the block takes it
    task automatic issue_op(input logic [OP_W-1:0] op, input logic signed [FIELD_W-1:0] val,
                            input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        reqs_sent++;
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input phase_t kind);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL: begin
                push_pct = 85;
                pop_pct  = 10;
            end
            PH_EMPTY: begin
                push_pct = 10;
                pop_pct  = 85;
            end
            default: begin
                push_pct = 45;
                pop_pct  = 45;
            end
        endcase
        if (r < push_pct)
            return OP_PUSH;
        if (r < push_pct + pop_pct)
            return OP_POP;
        // the rest is noise: queries and the unassigned code
        return (r[0]) ? OP_QUERY : OP_RSVD;
    endfunction

    // mix of extremes, a narrow band that makes equal values common, and full random
    function automatic logic signed [FIELD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5, 6: return $signed($urandom_range(0, 16)) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin : stimulus
        dir_row_t      dir_rows [0:25];
        stack_result_t predicted;
        phase_t        kind;
        int            phase_len;
        bit            no_gaps;
        int            random_reqs;

        // every input known from time zero, with reset asserted at the start
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_op    <= OP_QUERY;
        i_value <= '0;

        // directed table: typed expectations where they are obvious, predictor elsewhere
        dir_rows = '{
            // empty stack after reset, underflow, unassigned code on empty
            '{OP_QUERY, 32'sd0,  1'b1, EMPTY_OK},
            '{OP_POP,   32'sd0,  1'b1, EMPTY_UF},
            '{OP_RSVD,  -32'sd1, 1'b1, EMPTY_OK},
            // value extremes, minimum follows the most negative
            '{OP_PUSH,  VAL_MAX, 1'b1, '{32'sd0, VAL_MAX, VAL_MAX, 1'b0, ST_OK, 7'd1}},
            '{OP_PUSH,  VAL_MIN, 1'b1, '{32'sd0, VAL_MIN, VAL_MIN, 1'b0, ST_OK, 7'd2}},
            '{OP_PUSH,  32'sd0,  1'b1, '{32'sd0, 32'sd0, VAL_MIN, 1'b0, ST_OK, 7'd3}},
            '{OP_POP,   32'sd0,  1'b1, '{32'sd0, VAL_MIN, VAL_MIN, 1'b0, ST_OK, 7'd2}},
            '{OP_POP,   32'sd0,  1'b1, '{VAL_MIN, VAL_MAX, VAL_MAX, 1'b0, ST_OK, 7'd1}},
            '{OP_POP,   32'sd0,  1'b1, '{VAL_MAX, 32'sd0, 32'sd0, 1'b1, ST_OK, 7'd0}},
            '{OP_POP,   VAL_MAX, 1'b1, EMPTY_UF},
            // equal values on top of the minimum
            '{OP_PUSH,  32'sd5,  1'b0, UNCHECKED},
            '{OP_PUSH,  32'sd5,  1'b0, UNCHECKED},
            '{OP_PUSH,  32'sd7,  1'b0, UNCHECKED},
            '{OP_PUSH,  32'sd5,  1'b0, UNCHECKED},
            '{OP_PUSH,  -32'sd1, 1'b0, UNCHECKED},
            // value ignored by query and by the unassigned code
            '{OP_QUERY, VAL_MIN, 1'b0, UNCHECKED},
            '{OP_RSVD,  VAL_MAX, 1'b0, UNCHECKED},
            '{OP_POP,   VAL_MIN, 1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED},
            // alternating bit patterns
            '{OP_PUSH,  32'sh5555_5555, 1'b0, UNCHECKED},
            '{OP_PUSH,  32'shAAAA_AAAA, 1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED},
            '{OP_POP,   32'sd0,  1'b0, UNCHECKED}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            issue_op(dir_rows[k].op, dir_rows[k].value, $urandom_range(0, 4));
            predicted = predict_stack_op(dir_rows[k].op, dir_rows[k].value);
            owed_results.push_back(dir_rows[k].typed ? dir_rows[k].want : predicted);
        end

        // hold off until the directed results are all back
        drain_results();

        // random phases; the first one fills the stack so overflow is hit early
        random_reqs = 0;
        kind        = PH_FILL;
        phase_len   = 120;
        while (random_reqs < RANDOM_REQS) begin
            // the last phase stops at the request budget
            if (phase_len > RANDOM_REQS - random_reqs)
                phase_len = RANDOM_REQS - random_reqs;
            // about one phase in four runs back to back with no gaps
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                predicted = '0;
                begin : one_req
                    logic [OP_W-1:0]           op;
                    logic signed [FIELD_W-1:0] val;
                    op  = pick_op(kind);
                    val = pick_value();
                    issue_op(op, val, no_gaps ? 0 : $urandom_range(0, 4));
                    owed_results.push_back(predict_stack_op(op, val));
                end
                random_reqs++;
            end
            // sometimes let the block go fully quiet between phases
            if ($urandom_range(0, 2) == 0)
                drain_results();
            case ($urandom_range(0, 2))
                0:       kind = PH_FILL;
                1:       kind = PH_EMPTY;
                default: kind = PH_MIXED;
            endcase
            phase_len = $urandom_range(30, 120);
        end

        drain_results();
        // wait for any stray strobe to show up
        repeat (8) @(posedge i_clk);

        $display("ran %0d requests, %0d results compared, stack peaked at %0d of %0d entries",
                 reqs_sent, results_seen, peak_fill, STACK_DEPTH);
        $display("error paths exercised: %0d underflows, %0d overflows", n_underflow, n_overflow);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
